[rtl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the preemptive tick scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int TIME_BITS_DEF = 16;

	localparam int ID_W    = 8;
	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int OUT_W   = 16;

	typedef enum logic [1:0] {
		KIND_LOAD    = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  priority_lvl;
		logic [BURST_W-1:0] remaining;
	} task_entry_t;

	typedef struct packed {
		logic        found;
		logic        arrived_now;
		task_entry_t entry;
	} pick_t;

endpackage

[rtl/pts_task_mem.sv]
// ----------------------------------------------------------------------------
// pts_task_mem
// Task slot table: one write port, one registered read port, with a valid
// flop per slot so that a restart empties the table at once.
// ----------------------------------------------------------------------------
module pts_task_mem #(
	parameter int SLOTS  = pts_pkg::SLOTS_DEF,
	parameter int SLOT_W = $clog2(SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic                we,
	input  logic [SLOT_W-1:0]   wr_addr,
	input  pts_pkg::task_entry_t wr_data,
	input  logic                rd_en,
	input  logic [SLOT_W-1:0]   rd_addr,
	output pts_pkg::task_entry_t rd_data
);
	import pts_pkg::*;

	task_entry_t mem [SLOTS];
	task_entry_t rd_q;
	logic [SLOTS-1:0] vld_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// a never-written slot reads as an empty task
	always_comb begin
		rd_data = rd_q;
		if (!rd_vld_q) begin
			rd_data.remaining = '0;
		end
	end

endmodule

[rtl/pts_sel.sv]
// ----------------------------------------------------------------------------
// pts_sel
// Running best-task selection: compares one table entry per cycle, while en is
// high, against the present pick and keeps the winner.
// ----------------------------------------------------------------------------
module pts_sel #(
	parameter int SLOTS     = pts_pkg::SLOTS_DEF,
	parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF,
	parameter int SLOT_W    = $clog2(SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 en,
	input  logic [SLOT_W-1:0]    idx,
	input  pts_pkg::task_entry_t entry,
	input  logic [TIME_BITS-1:0] t,
	input  logic                 mode,
	input  logic                 cur_valid,
	input  logic [SLOT_W-1:0]    cur_slot,
	output pts_pkg::pick_t       pick,
	output logic [SLOT_W-1:0]    pick_slot
);
	import pts_pkg::*;

	localparam int CMP_W = TIME_BITS + ARR_W;

	task_entry_t     best_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic            found_q;
	logic            arrived_q;

	logic [CMP_W-1:0]   arr_w;
	logic [CMP_W-1:0]   t_w;
	logic               elig;
	logic               hit_now;
	logic [BURST_W-1:0] key_i;
	logic [BURST_W-1:0] key_b;
	logic               beats;
	logic               take;

	function automatic logic [BURST_W-1:0] key_of(input task_entry_t e, input logic m);
		logic [BURST_W-1:0] k;
		if (m) begin
			k = e.remaining;
		end else begin
			k = {{(BURST_W-PRIO_W){1'b0}}, e.priority_lvl};
		end
		return k;
	endfunction

	always_comb begin
		arr_w   = {{TIME_BITS{1'b0}}, entry.arrival};
		t_w     = {{ARR_W{1'b0}}, t};
		elig    = (entry.remaining != '0) && (arr_w <= t_w);
		hit_now = elig && (arr_w == t_w);
		key_i   = key_of(entry, mode);
		key_b   = key_of(best_q, mode);
		// tie: the task that ran last tick keeps the cpu, then lower id
		if (key_i != key_b) begin
			beats = key_i < key_b;
		end else if (cur_valid && best_slot_q == cur_slot) begin
			beats = 1'b0;
		end else if (cur_valid && idx == cur_slot) begin
			beats = 1'b1;
		end else begin
			beats = entry.id < best_q.id;
		end
		take = en && elig && (!found_q || beats);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			arrived_q <= 1'b0;
		end else if (clear) begin
			found_q   <= 1'b0;
			arrived_q <= 1'b0;
		end else if (en) begin
			if (take) begin
				found_q <= 1'b1;
			end
			if (hit_now) begin
				arrived_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q      <= entry;
			best_slot_q <= idx;
		end
	end

	assign pick.found       = found_q;
	assign pick.arrived_now = arrived_q;
	assign pick.entry       = best_q;
	assign pick_slot        = best_slot_q;

endmodule

[rtl/preemptive_tick_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// preemptive_tick_scheduler_unit
// Preemptive priority / shortest-remaining-time tick scheduler over a task
// slot table.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a clock edge with start high and busy low.
//   kind selects load (writes one slot), tick or restart (empties the table,
//   zeroes time and the running task; select_mode is kept).
//   Load and restart finish in the accept cycle, raise no busy and give no
//   result. A tick scans the table one slot per cycle through the single memory
//   read port and keeps busy high through the scan, a drain state and an
//   update state; the result follows with done high for one cycle as busy
//   drops. A new tick is taken only when busy is low again, so ticks never
//   overlap. select_mode is written through cfg_wr_en / cfg_wr_data; the user
//   must do so only while idle, as the block itself does not enforce it.
//   Results cannot be held off: the receiver must take each done cycle.
//   Reset empties the table, zeroes time and clears select_mode; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module preemptive_tick_scheduler_unit #(
	parameter int SLOTS     = pts_pkg::SLOTS_DEF,
	parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [3:0]  slot,
	input  logic [7:0]  task_id,
	input  logic [15:0] arrival_time,
	input  logic [15:0] burst_length,
	input  logic [7:0]  priority_level,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	output logic        done,
	output logic        busy_res,
	output logic [7:0]  running_id,
	output logic [15:0] tick_time,
	output logic        opens_segment,
	output logic        closes_previous,
	output logic        finished,
	output logic [15:0] turnaround,
	output logic [15:0] waiting_time
);
	import pts_pkg::*;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int WIDE_W = TIME_BITS + OUT_W;

	state_t state_q, state_nxt;

	logic                 mode_q;
	logic [TIME_BITS-1:0] time_q;
	logic                 cur_valid_q;
	logic [SLOT_W-1:0]    cur_slot_q;
	logic [SLOT_W-1:0]    scan_idx_q;
	logic                 rd_en_s1;
	logic [SLOT_W-1:0]    rd_idx_s1;

	logic        accept;
	logic        acc_load;
	logic        acc_tick;
	logic        acc_restart;
	logic        slot_ok;
	logic [31:0] slot_ext;
	logic        rd_en;
	logic        in_update;
	logic        scan_last;

	task_entry_t       load_entry;
	task_entry_t       upd_entry;
	task_entry_t       mem_wr_data;
	task_entry_t       rd_entry;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_wr_addr;

	pick_t             pick;
	logic [SLOT_W-1:0] pick_slot;

	logic [TIME_BITS-1:0] time_nxt;
	logic [WIDE_W-1:0]    t_wide;
	logic [WIDE_W-1:0]    tn_wide;
	logic [WIDE_W-1:0]    arr_wide;
	logic [WIDE_W-1:0]    burst_wide;
	logic [WIDE_W-1:0]    tat_diff;
	logic [WIDE_W-1:0]    tat_wide;
	logic [WIDE_W-1:0]    wt_diff;
	logic [WIDE_W-1:0]    wt_wide;
	logic [BURST_W-1:0]   new_rem;
	logic                 opens;
	logic                 closes;
	logic                 fin;

	// input decode
	always_comb begin
		accept      = start && !busy;
		acc_load    = 1'b0;
		acc_tick    = 1'b0;
		acc_restart = 1'b0;
		unique case (kind_t'(kind))
			KIND_LOAD:    acc_load    = accept;
			KIND_TICK:    acc_tick    = accept;
			KIND_RESTART: acc_restart = accept;
			default:      ;
		endcase
		slot_ext = {28'd0, slot};
		slot_ok  = slot_ext < 32'(SLOTS);
	end

	// state machine
	assign scan_last = (scan_idx_q == SLOT_W'(SLOTS - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (acc_tick) state_nxt = ST_SCAN;
			ST_SCAN:   if (scan_last) state_nxt = ST_DRAIN;
			ST_DRAIN:  state_nxt = ST_UPDATE;
			ST_UPDATE: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		rd_en     = 1'b0;
		in_update = 1'b0;
		unique case (state_q)
			ST_IDLE:   busy = 1'b0;
			ST_SCAN:   rd_en = 1'b1;
			ST_DRAIN:  ;
			ST_UPDATE: in_update = 1'b1;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			rd_en_s1   <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			rd_en_s1 <= rd_en;
			if (acc_tick) begin
				scan_idx_q <= '0;
			end else if (rd_en && !scan_last) begin
				scan_idx_q <= scan_idx_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;
	end

	// table write: loads while idle, remaining write-back at the end of a tick
	always_comb begin
		load_entry.id           = task_id;
		load_entry.arrival      = arrival_time;
		load_entry.burst        = burst_length;
		load_entry.priority_lvl = priority_level;
		load_entry.remaining    = burst_length;
		new_rem                 = pick.entry.remaining - BURST_W'(1);
		upd_entry               = pick.entry;
		upd_entry.remaining     = new_rem;
		if (in_update) begin
			mem_we      = pick.found;
			mem_wr_addr = pick_slot;
			mem_wr_data = upd_entry;
		end else begin
			mem_we      = acc_load && slot_ok;
			mem_wr_addr = slot_ext[SLOT_W-1:0];
			mem_wr_data = load_entry;
		end
	end

	pts_task_mem #(
		.SLOTS  (SLOTS),
		.SLOT_W (SLOT_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (acc_restart),
		.we      (mem_we),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q),
		.rd_data (rd_entry)
	);

	pts_sel #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS),
		.SLOT_W    (SLOT_W)
	) u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (acc_tick),
		.en        (rd_en_s1),
		.idx       (rd_idx_s1),
		.entry     (rd_entry),
		.t         (time_q),
		.mode      (mode_q),
		.cur_valid (cur_valid_q),
		.cur_slot  (cur_slot_q),
		.pick      (pick),
		.pick_slot (pick_slot)
	);

	// tick outcome, all times taken modulo the time counter width
	always_comb begin
		time_nxt   = time_q + TIME_BITS'(1);
		t_wide     = {{OUT_W{1'b0}}, time_q};
		tn_wide    = {{OUT_W{1'b0}}, time_nxt};
		arr_wide   = {{TIME_BITS{1'b0}}, pick.entry.arrival};
		burst_wide = {{TIME_BITS{1'b0}}, pick.entry.burst};
		tat_diff   = tn_wide - arr_wide;
		tat_wide   = {{OUT_W{1'b0}}, tat_diff[TIME_BITS-1:0]};
		wt_diff    = tat_wide - burst_wide;
		wt_wide    = {{OUT_W{1'b0}}, wt_diff[TIME_BITS-1:0]};
		opens      = !cur_valid_q || (cur_slot_q != pick_slot) || pick.arrived_now;
		closes     = cur_valid_q && opens;
		fin        = (new_rem == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			time_q      <= '0;
			cur_valid_q <= 1'b0;
			cur_slot_q  <= '0;
			done        <= 1'b0;
		end else begin
			done <= in_update;
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (acc_restart) begin
				time_q      <= '0;
				cur_valid_q <= 1'b0;
				cur_slot_q  <= '0;
			end else if (in_update) begin
				time_q <= time_nxt;
				if (!pick.found || fin) begin
					cur_valid_q <= 1'b0;
				end else begin
					cur_valid_q <= 1'b1;
					cur_slot_q  <= pick_slot;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_update) begin
			tick_time <= t_wide[OUT_W-1:0];
			if (pick.found) begin
				busy_res        <= 1'b1;
				running_id      <= pick.entry.id;
				opens_segment   <= opens;
				closes_previous <= closes;
				finished        <= fin;
				turnaround      <= fin ? tat_wide[OUT_W-1:0] : '0;
				waiting_time    <= fin ? wt_wide[OUT_W-1:0] : '0;
			end else begin
				busy_res        <= 1'b0;
				running_id      <= '0;
				opens_segment   <= 1'b0;
				closes_previous <= cur_valid_q;
				finished        <= 1'b0;
				turnaround      <= '0;
				waiting_time    <= '0;
			end
		end
	end

`ifndef SYNTH
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPDATE))
		else $error("result strobe without a finished scan");

	a_finish_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		done && finished |-> busy_res)
		else $error("completion reported on an idle tick");

	a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && !busy_res |-> running_id == '0 && !opens_segment && !finished)
		else $error("idle tick reports a running task");

	a_no_read_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !rd_en_s1 && !rd_en)
		else $error("table read in flight while idle");
`endif

endmodule
